@@ hdl/cpps_pkg.sv @@
// Shared types and constants of the closest projected point search core.
// Used by cpps_div and closest_projected_point_search_core; depends on nothing.
package cpps_pkg;

    // Point and result field widths
    localparam int COORD_W   = 32;
    localparam int PIX_W     = 24;
    localparam int INDEX_W   = 16;

    // Divider geometry: quotient bits, dividend and divisor widths
    localparam int QUO_W     = 28;
    localparam int DVND_W    = 64;
    localparam int DVSR_W    = 39;
    localparam int DVS_W     = DVSR_W + QUO_W - 1;
    localparam int STEP_W    = 5;

    // Saturated pixel difference and squared distance widths
    localparam int DMAG_W    = 25;
    localparam int DIST_W    = 50;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 3;
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_HALF_WIDTH   = 3'd0,
        CFG_HALF_HEIGHT  = 3'd1,
        CFG_SCALE_X      = 3'd2,
        CFG_SCALE_Y      = 3'd3,
        CFG_QUERY_X      = 3'd4,
        CFG_QUERY_Y      = 3'd5,
        CFG_MAX_DISTANCE = 3'd6
    } t_cfg_idx;

    // Sequencer states, one-hot
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_MULY   = 9'b000000010,
        S_DIVY   = 9'b000000100,
        S_MULZ   = 9'b000001000,
        S_DIVZ   = 9'b000010000,
        S_SQX    = 9'b000100000,
        S_SQY    = 9'b001000000,
        S_LIM    = 9'b010000000,
        S_DECIDE = 9'b100000000
    } t_state;

    // Divider control from the sequencer
    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctl;

endpackage

@@ hdl/cpps_div.sv @@
// Restoring divider, one quotient bit per cycle while i_ctl.step is high, for the projection offsets.
// Depends on cpps_pkg for widths and the control struct.
module cpps_div (
    input  logic                            i_clk,
    input  cpps_pkg::t_div_ctl              i_ctl,
    input  logic [cpps_pkg::DVND_W-1:0]     i_dividend,
    input  logic [cpps_pkg::DVSR_W-1:0]     i_divisor,
    output logic [cpps_pkg::QUO_W-1:0]      o_quot
);

    logic [cpps_pkg::DVND_W-1:0] r_rem;
    logic [cpps_pkg::DVS_W-1:0]  r_dvs;
    logic [cpps_pkg::QUO_W-1:0]  r_quo;
    logic                        ge;

    // Compare remainder against the shifted divisor
    assign ge = {{(cpps_pkg::DVS_W-cpps_pkg::DVND_W){1'b0}}, r_rem} >= r_dvs;

    // Load operands, then subtract and shift one bit each step.
    // The first quotient bit flags a quotient too large to matter.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rem <= i_dividend;
            r_dvs <= {i_divisor, {(cpps_pkg::QUO_W-1){1'b0}}};
            r_quo <= '0;
        end else if (i_ctl.step) begin
            if (ge) begin
                r_rem <= r_rem - r_dvs[cpps_pkg::DVND_W-1:0];
            end
            r_quo <= {r_quo[cpps_pkg::QUO_W-2:0], ge};
            r_dvs <= r_dvs >> 1;
        end
    end

    assign o_quot = r_quo;

endmodule

@@ hdl/closest_projected_point_search_core.sv @@
// Top level of the closest projected point search: sequencer, shared multiplier,
// configuration registers, search state and output register. Depends on cpps_pkg, cpps_div.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------------
//  s       | in        | i_s_tvalid / o_s_tready    | tdata: point_x, point_y, point_z; tlast
//  m       | out       | o_m_tvalid / i_m_tready    | tdata: best_index, best_x/y/z; tuser
//  cfg     | in        | i_cfg_valid / o_cfg_ready  | i_cfg_addr register index, i_cfg_data
//
// A point with positive depth occupies the sequencer from its acceptance until the next one can
// be taken: one multiply and 28 divider steps per projected axis, three multiplies, a compare
// and the idle state that takes the next point; the bit-serial divider takes most of that time.
// A point with depth <= 0 goes from idle straight to the compare and back. On the last point
// of a run the sequencer waits until the output register is free.
// Reset (synchronous, active low) restores the register defaults and clears the search.
// Configuration writes are always taken (o_cfg_ready is high).
module closest_projected_point_search_core #(
    parameter int MAX_POINTS = 65536
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [3*cpps_pkg::COORD_W-1:0]     i_s_tdata,   // point_x, point_y, point_z
    input  logic                               i_s_tlast,   // last_point
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [cpps_pkg::INDEX_W+3*cpps_pkg::COORD_W-1:0] o_m_tdata, // best_index, best_x,
                                                                        // best_y, best_z
    output logic                               o_m_tuser,   // found
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [cpps_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [31:0]                        i_cfg_data
);

    localparam int CW = cpps_pkg::COORD_W;
    localparam int PW = cpps_pkg::PIX_W;
    localparam int IW = cpps_pkg::INDEX_W;
    localparam int DW = cpps_pkg::DIST_W;
    localparam int MW = cpps_pkg::DMAG_W;

    // Configuration registers
    logic [PW-1:0]        r_half_width, r_half_height, r_max_dist;
    logic [CW-1:0]        r_scale_x, r_scale_y;
    logic [PW-1:0]        r_query_x, r_query_y;

    // Sequencer and working registers
    cpps_pkg::t_state     r_state;
    logic [cpps_pkg::STEP_W-1:0] r_step;
    logic [CW-1:0]        r_px, r_py, r_pz;
    logic                 r_last, r_skip;
    logic [MW-1:0]        r_dmx, r_dmy;
    logic [2*CW-1:0]      r_prod;
    logic [DW-1:0]        r_acc;

    // Search state
    logic                 r_have;
    logic [DW-1:0]        r_best_dist;
    logic [IW-1:0]        r_best_pos, r_cnt;
    logic [CW-1:0]        r_best_x, r_best_y, r_best_z;

    // Output register
    logic                 r_out_valid;
    logic                 r_out_found;
    logic [IW+3*CW-1:0]   r_out_data;

    // Datapath signals
    logic                 s_acc;
    logic [CW-1:0]        op_a, op_b;
    logic [2*CW-1:0]      mul_out;
    logic [CW-1:0]        mag_y, mag_z;
    cpps_pkg::t_div_ctl   div_ctl;
    logic [cpps_pkg::DVSR_W-1:0] divisor;
    logic [cpps_pkg::QUO_W-1:0]  quot;
    logic [MW-1:0]        diff_now;
    logic                 upd, out_busy, hold, step_end, depth_bad;
    logic [IW:0]          cnt_inc;
    logic [IW-1:0]        cnt_next;

    // Saturated magnitude of base + (neg ? -q : q) - query; a set top quotient bit
    // means the offset alone exceeds any accepted distance
    function automatic logic [cpps_pkg::DMAG_W-1:0] f_diff_mag(
        input logic [cpps_pkg::QUO_W-1:0] q,
        input logic                       neg,
        input logic [cpps_pkg::PIX_W-1:0] base,
        input logic [cpps_pkg::PIX_W-1:0] query
    );
        logic [29:0] off;
        logic [29:0] v;
        logic [29:0] m;
        off = {3'b000, q[cpps_pkg::QUO_W-2:0]};
        v = {6'b000000, base} - {{6{query[cpps_pkg::PIX_W-1]}}, query}
            + (neg ? (30'd0 - off) : off);
        m = v[29] ? (30'd0 - v) : v;
        if (q[cpps_pkg::QUO_W-1] || (m > 30'h1000000)) begin
            f_diff_mag = 25'h1000000;
        end else begin
            f_diff_mag = m[cpps_pkg::DMAG_W-1:0];
        end
    endfunction

    assign s_acc       = i_s_tvalid && o_s_tready;
    assign o_s_tready  = (r_state == cpps_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign depth_bad   = i_s_tdata[CW-1] || (i_s_tdata[CW-1:0] == '0);

    // Magnitudes of the lateral coordinates
    assign mag_y = r_py[CW-1] ? (CW'(0) - r_py) : r_py;
    assign mag_z = r_pz[CW-1] ? (CW'(0) - r_pz) : r_pz;

    // Shared multiplier operand selection
    always_comb begin
        op_a = mag_y;
        op_b = r_scale_x;
        case (r_state)
            cpps_pkg::S_MULZ: begin
                op_a = mag_z;
                op_b = r_scale_y;
            end
            cpps_pkg::S_SQX: begin
                op_a = {7'b0, r_dmx};
                op_b = {7'b0, r_dmx};
            end
            cpps_pkg::S_SQY: begin
                op_a = {7'b0, r_dmy};
                op_b = {7'b0, r_dmy};
            end
            cpps_pkg::S_LIM: begin
                op_a = {8'b0, r_max_dist};
                op_b = {8'b0, r_max_dist};
            end
            default: begin
                op_a = mag_y;
                op_b = r_scale_x;
            end
        endcase
    end

    assign mul_out = op_a * op_b;

    // Divider: divisor is depth times 256
    assign divisor      = {r_px[CW-2:0], 8'b0};
    assign div_ctl.load = (r_state == cpps_pkg::S_MULY) || (r_state == cpps_pkg::S_MULZ);
    assign div_ctl.step = (r_state == cpps_pkg::S_DIVY) || (r_state == cpps_pkg::S_DIVZ);
    assign step_end     = (r_step == cpps_pkg::STEP_W'(cpps_pkg::QUO_W - 1));

    cpps_div u_div (
        .i_clk      (i_clk),
        .i_ctl      (div_ctl),
        .i_dividend (mul_out),
        .i_divisor  (divisor),
        .o_quot     (quot)
    );

    // Pixel difference from the finished quotient of the current axis
    assign diff_now = (r_state == cpps_pkg::S_MULZ)
                    ? f_diff_mag(quot, r_py[CW-1], r_half_width, r_query_x)
                    : f_diff_mag(quot, !r_pz[CW-1], r_half_height, r_query_y);

    // Acceptance and improvement test; r_prod holds the limit squared here
    assign upd = !r_skip && (r_acc <= r_prod[DW-1:0])
              && (!r_have || (r_acc < r_best_dist));
    assign out_busy = r_out_valid && !i_m_tready;
    assign hold     = r_last && out_busy;

    // Position counter wraps at MAX_POINTS and at 16 bits
    assign cnt_inc  = {1'b0, r_cnt} + (IW+1)'(1);
    assign cnt_next = (32'(cnt_inc) == 32'(MAX_POINTS)) ? '0 : cnt_inc[IW-1:0];

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width  <= 24'd245760;
            r_half_height <= 24'd138240;
            r_scale_x     <= 32'd62914560;
            r_scale_y     <= 32'd62914560;
            r_query_x     <= '0;
            r_query_y     <= '0;
            r_max_dist    <= '0;
        end else if (i_cfg_valid) begin
            unique case (cpps_pkg::t_cfg_idx'(i_cfg_addr))
                cpps_pkg::CFG_HALF_WIDTH:   r_half_width  <= i_cfg_data[PW-1:0];
                cpps_pkg::CFG_HALF_HEIGHT:  r_half_height <= i_cfg_data[PW-1:0];
                cpps_pkg::CFG_SCALE_X:      r_scale_x     <= i_cfg_data;
                cpps_pkg::CFG_SCALE_Y:      r_scale_y     <= i_cfg_data;
                cpps_pkg::CFG_QUERY_X:      r_query_x     <= i_cfg_data[PW-1:0];
                cpps_pkg::CFG_QUERY_Y:      r_query_y     <= i_cfg_data[PW-1:0];
                cpps_pkg::CFG_MAX_DISTANCE: r_max_dist    <= i_cfg_data[PW-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cpps_pkg::S_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                cpps_pkg::S_IDLE: begin
                    if (s_acc) begin
                        r_state <= depth_bad ? cpps_pkg::S_DECIDE : cpps_pkg::S_MULY;
                    end
                end
                cpps_pkg::S_MULY: begin
                    r_step  <= '0;
                    r_state <= cpps_pkg::S_DIVY;
                end
                cpps_pkg::S_DIVY: begin
                    r_step <= r_step + 1'b1;
                    if (step_end) begin
                        r_state <= cpps_pkg::S_MULZ;
                    end
                end
                cpps_pkg::S_MULZ: begin
                    r_step  <= '0;
                    r_state <= cpps_pkg::S_DIVZ;
                end
                cpps_pkg::S_DIVZ: begin
                    r_step <= r_step + 1'b1;
                    if (step_end) begin
                        r_state <= cpps_pkg::S_SQX;
                    end
                end
                cpps_pkg::S_SQX:    r_state <= cpps_pkg::S_SQY;
                cpps_pkg::S_SQY:    r_state <= cpps_pkg::S_LIM;
                cpps_pkg::S_LIM:    r_state <= cpps_pkg::S_DECIDE;
                cpps_pkg::S_DECIDE: begin
                    if (!hold) begin
                        r_state <= cpps_pkg::S_IDLE;
                    end
                end
                default: r_state <= cpps_pkg::S_IDLE;
            endcase
        end
    end

    // Capture the point and run the distance datapath
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_px   <= i_s_tdata[CW-1:0];
            r_py   <= i_s_tdata[2*CW-1:CW];
            r_pz   <= i_s_tdata[3*CW-1:2*CW];
            r_last <= i_s_tlast;
            r_skip <= depth_bad;
        end
        case (r_state)
            cpps_pkg::S_MULZ: r_dmx <= diff_now;
            cpps_pkg::S_SQX: begin
                r_dmy  <= diff_now;
                r_prod <= mul_out;
            end
            cpps_pkg::S_SQY: begin
                r_acc  <= r_prod[DW-1:0];
                r_prod <= mul_out;
            end
            cpps_pkg::S_LIM: begin
                r_acc  <= r_acc + r_prod[DW-1:0];
                r_prod <= mul_out;
            end
            default: ;
        endcase
    end

    // Search state: keep the first closest accepted point; clear after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_cnt  <= '0;
        end else if (r_state == cpps_pkg::S_DECIDE && !hold) begin
            if (r_last) begin
                r_have <= 1'b0;
                r_cnt  <= '0;
            end else begin
                r_cnt <= cnt_next;
                if (upd) begin
                    r_have <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == cpps_pkg::S_DECIDE && !hold && upd) begin
            r_best_dist <= r_acc;
            r_best_pos  <= r_cnt;
            r_best_x    <= r_px;
            r_best_y    <= r_py;
            r_best_z    <= r_pz;
        end
    end

    // Output register: drain on handshake, load the run result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == cpps_pkg::S_DECIDE && r_last && !out_busy) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == cpps_pkg::S_DECIDE && r_last && !out_busy) begin
            r_out_found <= upd || r_have;
            if (upd) begin
                r_out_data <= {r_pz, r_py, r_px, r_cnt};
            end else if (r_have) begin
                r_out_data <= {r_best_z, r_best_y, r_best_x, r_best_pos};
            end else begin
                r_out_data <= '0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_found;

    // An accepted point takes the sequencer out of idle, so ready drops after each acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_tready)
        else $error("ready high right after a point was accepted");

    // Results only come out of the decide step
    a_result_from_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == cpps_pkg::S_DECIDE) && $past(r_last))
        else $error("result raised outside the decide step of a last point");

    // The Y-axis divider runs its full step count before leaving
    a_div_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == cpps_pkg::S_DIVY) && !step_end) |=> (r_state == cpps_pkg::S_DIVY))
        else $error("divider left before its last step");

    // An empty search reports zero fields
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("nothing found but result fields nonzero");

endmodule

@@ tb/sv/closest_projected_point_search_core_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of closest_projected_point_search_core: drives runs of depth points
// on the stream input and register writes on the configuration port and compares each search result with a predictor.
// Depends on cpps_pkg and the core RTL.
module closest_projected_point_search_core_test;
    import cpps_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 100;
    localparam int PHASES        = 9;
    localparam int PHASE_POINTS  = 150;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 3'd7;

    // Register values after reset
    localparam bit [31:0] HALF_W_RST = 32'd245760;
    localparam bit [31:0] HALF_H_RST = 32'd138240;
    localparam bit [31:0] SCALE_RST  = 32'd62914560;

    // Saturation bound of a pixel difference
    localparam bit [63:0] DIFF_SAT = 64'd16777216;

    typedef struct packed {
        bit        found;
        bit [15:0] pos;
        bit [31:0] px;
        bit [31:0] py;
        bit [31:0] pz;
    } search_result_t;

    // Mirror of the search state and register file; holds the results still to come
    class nearest_point_scoreboard;
        bit [PIX_W-1:0]   half_w, half_h, query_x, query_y, max_dist;
        bit [31:0]        scale_x, scale_y;
        bit               have_best;
        bit [DIST_W-1:0]  best_dist;
        bit [INDEX_W-1:0] best_pos, next_pos;
        bit [31:0]        best_x, best_y, best_z;
        search_result_t   pending[$];
        int               errors;

        function new();
            half_w   = HALF_W_RST[PIX_W-1:0];
            half_h   = HALF_H_RST[PIX_W-1:0];
            scale_x  = SCALE_RST;
            scale_y  = SCALE_RST;
            query_x  = '0;
            query_y  = '0;
            max_dist = '0;
            errors   = 0;
            clear_search();
        endfunction

        function void clear_search();
            have_best = 1'b0;
            best_dist = '0;
            best_pos  = '0;
            best_x    = '0;
            best_y    = '0;
            best_z    = '0;
            next_pos  = '0;
        endfunction

        function void write_reg(bit [CFG_ADDR_W-1:0] idx, bit [31:0] d);
            case (idx)
                CFG_HALF_WIDTH:   half_w   = d[PIX_W-1:0];
                CFG_HALF_HEIGHT:  half_h   = d[PIX_W-1:0];
                CFG_SCALE_X:      scale_x  = d;
                CFG_SCALE_Y:      scale_y  = d;
                CFG_QUERY_X:      query_x  = d[PIX_W-1:0];
                CFG_QUERY_Y:      query_y  = d[PIX_W-1:0];
                CFG_MAX_DISTANCE: max_dist = d[PIX_W-1:0];
                default: ;
            endcase
        endfunction

        // Q16.8 pixel offset |c|*scale/(x*256), truncated, with the sign of c
        function longint proj_offset(longint c, bit [31:0] scale, longint x);
            bit [63:0] mag, q;
            mag = (c < 0) ? -c : c;
            q = (mag * 64'(scale)) / (64'(x) << 8);
            return (c < 0) ? -longint'(q) : longint'(q);
        endfunction

        function bit [63:0] sat_square(longint d);
            bit [63:0] m;
            m = (d < 0) ? -d : d;
            if (m > DIFF_SAT)
                m = DIFF_SAT;
            return m * m;
        endfunction

        // Project one accepted point, update the best candidate, close the run on last
        function void note_point(bit [31:0] px, bit [31:0] py, bit [31:0] pz, bit last);
            longint         x, dx, dy;
            bit [63:0]      d_sq, lim;
            search_result_t res;
            x = longint'($signed(px));
            if (x > 0) begin
                dx = longint'(half_w) + proj_offset(longint'($signed(py)), scale_x, x)
                     - longint'($signed(query_x));
                dy = longint'(half_h) - proj_offset(longint'($signed(pz)), scale_y, x)
                     - longint'($signed(query_y));
                d_sq = sat_square(dx) + sat_square(dy);
                lim  = 64'(max_dist) * 64'(max_dist);
                if (d_sq <= lim && (!have_best || d_sq < 64'(best_dist))) begin
                    have_best = 1'b1;
                    best_dist = d_sq[DIST_W-1:0];
                    best_pos  = next_pos;
                    best_x    = px;
                    best_y    = py;
                    best_z    = pz;
                end
            end
            next_pos = next_pos + 1'b1;
            if (last) begin
                res.found = have_best;
                res.pos   = have_best ? best_pos : '0;
                res.px    = have_best ? best_x : '0;
                res.py    = have_best ? best_y : '0;
                res.pz    = have_best ? best_z : '0;
                pending.push_back(res);
                clear_search();
            end
        endfunction

        task report(string field, bit [31:0] got, bit [31:0] want);
            $display("ERROR: %s mismatch at %0t: got 0x%08h, expected 0x%08h",
                     field, $realtime, got, want);
            errors++;
        endtask

        task check_result(search_result_t got);
            search_result_t want;
            if (pending.size() == 0) begin
                report("unexpected result, best_index", 32'(got.pos), '0);
                return;
            end
            want = pending.pop_front();
            if (got.found != want.found) report("found", 32'(got.found), 32'(want.found));
            if (got.pos != want.pos)     report("best_index", 32'(got.pos), 32'(want.pos));
            if (got.px != want.px)       report("best_x", got.px, want.px);
            if (got.py != want.py)       report("best_y", got.py, want.py);
            if (got.pz != want.pz)       report("best_z", got.pz, want.pz);
        endtask
    endclass

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_s_tvalid;
    logic                               o_s_tready;
    logic [3*COORD_W-1:0]               i_s_tdata;   // point_x, point_y, point_z
    logic                               i_s_tlast;   // last_point
    logic                               o_m_tvalid;
    logic                               i_m_tready;
    logic [INDEX_W+3*COORD_W-1:0]       o_m_tdata;   // best_index, best_x, best_y, best_z
    logic                               o_m_tuser;   // found
    logic                               i_cfg_valid;
    logic                               o_cfg_ready;
    logic [CFG_ADDR_W-1:0]              i_cfg_addr;
    logic [31:0]                        i_cfg_data;

    nearest_point_scoreboard sb = new();
    bit                      idle_on;
    int                      cycle_count = 0;

    closest_projected_point_search_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Check every result transaction against the oldest expectation
    always @(posedge i_clk) begin : result_monitor
        search_result_t got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.found = o_m_tuser;
            got.pos   = o_m_tdata[15:0];
            got.px    = o_m_tdata[47:16];
            got.py    = o_m_tdata[79:48];
            got.pz    = o_m_tdata[111:80];
            sb.check_result(got);
        end
    end

    // Result sink: accept in bursts, stall in bursts while idling is on
    initial begin : result_sink
        int unsigned n;
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            n = $urandom_range(1, 24);
            repeat (n) @(negedge i_clk) i_m_tready <= 1'b1;
            if (idle_on) begin
                n = $urandom_range(1, 16);
                repeat (n) @(negedge i_clk) i_m_tready <= 1'b0;
            end
        end
    end

    // Offer one point and hold it until the core takes it
    task automatic send_point(bit [31:0] px, bit [31:0] py, bit [31:0] pz, bit last);
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {pz, py, px};
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_point(px, py, pz, last);
    endtask

    task automatic hold_off(int n);
        @(negedge i_clk) i_s_tvalid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic sender_gap();
        if (idle_on && $urandom_range(0, 3) == 0)
            hold_off($urandom_range(1, 16));
    endtask

    task automatic release_sender();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        i_s_tlast  <= 1'b0;
    endtask

    // Wait for every expected result, then let the core settle
    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, bit [31:0] d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, d);
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    task automatic cfg_write_all(bit [31:0] hw, bit [31:0] hh, bit [31:0] sx, bit [31:0] sy,
                                 bit [31:0] qx, bit [31:0] qy, bit [31:0] md);
        cfg_write(CFG_HALF_WIDTH, hw);
        cfg_write(CFG_HALF_HEIGHT, hh);
        cfg_write(CFG_SCALE_X, sx);
        cfg_write(CFG_SCALE_Y, sy);
        cfg_write(CFG_QUERY_X, qx);
        cfg_write(CFG_QUERY_Y, qy);
        cfg_write(CFG_MAX_DISTANCE, md);
        cfg_write(CFG_UNUSED, $urandom());
    endtask

    // Default screen, query 3 px left and 4 px up of center, limit 5 px
    task automatic program_near_center();
        cfg_write_all(HALF_W_RST, HALF_H_RST, SCALE_RST, SCALE_RST,
                      32'd244992, 32'd137216, 32'd1280);
    endtask

    // Extremes on some phases, random screens around the query otherwise
    task automatic program_phase(int p);
        bit [31:0] hw, hh, sx, sy, qx, qy, md;
        case (p % 4)
            0: begin
                cfg_write_all(32'hFF_FFFF, 32'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              32'h7F_FFFF, 32'h80_0000, 32'hFF_FFFF);
            end
            1: begin
                cfg_write_all('0, '0, '0, 32'd1, '0, '0, '0);
            end
            default: begin
                hw = $urandom_range(0, 32'h3F_FFFF);
                hh = $urandom_range(0, 32'h3F_FFFF);
                sx = $urandom_range(32'h0001_0000, 32'h1000_0000);
                sy = $urandom_range(32'h0001_0000, 32'h1000_0000);
                qx = hw + $urandom_range(0, 131072) - 32'd65536;
                qy = hh + $urandom_range(0, 131072) - 32'd65536;
                md = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'hFF_FFFF)
                                                 : $urandom_range(0, 32'h1_0000);
                if (p % 4 == 2) begin
                    qx = 32'h80_0000;
                    qy = 32'h7F_FFFF;
                end
                cfg_write_all(hw, hh, sx, sy, qx, qy, md);
            end
        endcase
    endtask

    // Coordinate that projects to the given offset at depth x, or noise when it cannot
    function automatic bit [31:0] aim_coord(longint off, bit [31:0] scale, longint x);
        longint c;
        if (scale == 0)
            return $urandom();
        c = off * x * 256 / longint'(scale);
        if (c != longint'($signed(c[31:0])))
            return $urandom();
        return c[31:0];
    endfunction

    function automatic bit [31:0] skip_depth();
        return ($urandom_range(0, 3) == 0) ? 32'd0 : (32'h8000_0000 | $urandom());
    endfunction

    // Mostly points aimed around the query pixel, plus noise, skipped depths and repeats
    function automatic bit [95:0] random_point(bit [95:0] prev, bit have_prev);
        int unsigned kind;
        longint      x, md, nx, nz;
        bit [31:0]   py, pz;
        kind = $urandom_range(0, 99);
        if (kind < 15)
            return {$urandom(), $urandom(), $urandom()};
        if (kind < 25)
            return {$urandom(), $urandom(), skip_depth()};
        if (kind < 32 && have_prev)
            return prev;
        x  = longint'($urandom_range(1, 32'hFF_FFFF));
        md = longint'(sb.max_dist);
        nx = longint'($urandom_range(0, 2 * md + 2)) - (md + 1);
        nz = longint'($urandom_range(0, 2 * md + 2)) - (md + 1);
        py = aim_coord(longint'($signed(sb.query_x)) - longint'(sb.half_w) + nx, sb.scale_x, x);
        pz = aim_coord(longint'(sb.half_h) - longint'($signed(sb.query_y)) + nz, sb.scale_y, x);
        return {pz, py, x[31:0]};
    endfunction

    task automatic run_random_phase(int p, bit idle);
        int        sent, len;
        bit [95:0] pt, prev;
        bit        have_prev;
        idle_on = idle;
        program_phase(p);
        sent = 0;
        prev = '0;
        while (sent < PHASE_POINTS) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
            have_prev = 1'b0;
            for (int i = 0; i < len; i++) begin
                pt = random_point(prev, have_prev);
                send_point(pt[31:0], pt[63:32], pt[95:64], i == len - 1);
                prev = pt;
                have_prev = 1'b1;
                sender_gap();
            end
            sent += len;
        end
        release_sender();
        drain();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tlast   = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_addr  = CFG_HALF_WIDTH;
        i_cfg_data  = '0;
        idle_on     = 1'b1;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Register defaults, zero limit: only an exact hit on the query pixel counts
        send_point(32'd65536, 32'hFFFF_0000, 32'h0000_9000, 1'b1);
        // Zero, negative and most negative depths are skipped but keep their positions
        send_point(32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_point(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 1'b0);
        send_point(32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_point(32'd65536, 32'hFFFF_0000, 32'h0000_9000, 1'b1);
        // Far differences saturate; nothing found
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_point(32'd1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        release_sender();
        drain();

        // Tie with the limit, repeated equal distances keep the first, then a closer one
        program_near_center();
        send_point(32'd65536, '0, '0, 1'b0);
        send_point(32'd131072, '0, '0, 1'b0);
        send_point(32'd65536, '0, '0, 1'b0);
        send_point(32'd65536, 32'hFFFF_FF00, '0, 1'b1);
        send_point(32'd65536, '0, '0, 1'b0);
        send_point(32'd65536, 32'd256, '0, 1'b1);
        release_sender();
        drain();

        for (int p = 0; p < PHASES; p++) begin
            run_random_phase(p, p != PHASES - 1);
        end

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
